// File: sv/uer_pkg.sv
`default_nettype none

package uer_pkg;

  localparam int unsigned US_W = 18;
  localparam int unsigned DIST_W = 23;
  localparam int unsigned PRESC_W = 11;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 18;

  localparam logic [US_W-1:0] US_MAX = 18'h3FFFF;
  localparam logic [DIST_W-1:0] DIST_MAX = 23'h7FFFFF;

  // distance = t * (33150 + 6 * T) / 1000, the divide split into >> 3 and / 125
  localparam logic signed [16:0] SPEED_BASE = 17'sd33150;
  localparam logic signed [16:0] SPEED_SLOPE = 17'sd6;
  localparam logic [31:0] RECIP_125 = 32'd2199023256;
  localparam int unsigned RECIP_SHIFT = 38;

  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_US = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEMPERATURE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_US = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_WAIT_US = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ONE_WAY_US = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF_US = 3'd5;

  typedef struct packed {
    logic [9:0]      ticks_per_us;
    logic [7:0]      trigger_us;
    logic [US_W-1:0] edge_wait_us;
    logic [US_W-1:0] max_one_way_us;
    logic [15:0]     holdoff_us;
  } timing_cfg_t;

  typedef struct packed {
    logic            pin_drive_high;
    logic            pin_is_output;
    logic            busy_res;
    logic            done_res;
    logic            status;
    logic [US_W-1:0] echo_time_us;
    logic            dist_en;
  } meas_t;

  typedef struct packed {
    logic ld2;
    logic ld3;
  } pipe_ld_t;

endpackage

`default_nettype wire

// File: sv/ultrasonic_echo_ranger.sv
// Ultrasonic echo ranger with temperature compensation.
// Each input word on s_* is one timer tick: bit 0 start_req, bit 1 the
// sampled echo pin level. Every accepted word gives exactly one output word
// on m_* with the pin controls, busy flag and, on the tick a measurement
// ends, done, status, echo time in us and distance in 10 um units.
// The control state advances once per accepted word, one tick per word;
// the block takes one word per cycle while m_tready does not stall the output.
// Pipeline: each accepted word passes the state update, the time*speed multiply,
// the reciprocal divide by 1000 and the saturating output register.
// Configuration is written through cfg_we/cfg_idx/cfg_wdata while no
// measurement words are in flight; indexes 6 and 7 are ignored.
// Reset puts the controller in idle, clears the counters and empties the
// pipeline; registers return to 240 ticks/us, 20.0 C, 5 us trigger,
// 185000 us edge wait and one-way limit, 200 us holdoff.
// When m_tready is low the words back up stage by stage; s_tready drops
// only once all four stages hold words.
`default_nettype none

module ultrasonic_echo_ranger (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              s_tvalid,
  output logic                             s_tready,
  input  wire [7:0]                        s_tdata,   // start_req, echo_level
  output logic                             m_tvalid,
  input  wire                              m_tready,
  // pin_drive_high, pin_is_output, busy_res, done_res, status,
  // echo_time_us[17:0], distance_10um[22:0]
  output logic [47:0]                      m_tdata,
  input  wire                              cfg_we,
  input  wire [uer_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  wire [uer_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import uer_pkg::*;

  timing_cfg_t        cfg;
  logic signed [11:0] temperature_tenths;

  logic               accept;
  logic               v1, v2, v3, vo;
  logic               rdy1, rdy2, rdy3, rdyo;
  logic               ldo;
  pipe_ld_t           ld;
  meas_t              res, s1, s2, s3, om;
  logic [DIST_W-1:0]  dist_sat, odist;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ticks_per_us   <= 10'd240;
      temperature_tenths <= 12'sd200;
      cfg.trigger_us     <= 8'd5;
      cfg.edge_wait_us   <= 18'd185000;
      cfg.max_one_way_us <= 18'd185000;
      cfg.holdoff_us     <= 16'd200;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_TICKS_PER_US:   cfg.ticks_per_us   <= cfg_wdata[9:0];
        REG_TEMPERATURE:    temperature_tenths <= cfg_wdata[11:0];
        REG_TRIGGER_US:     cfg.trigger_us     <= cfg_wdata[7:0];
        REG_EDGE_WAIT_US:   cfg.edge_wait_us   <= cfg_wdata;
        REG_MAX_ONE_WAY_US: cfg.max_one_way_us <= cfg_wdata;
        REG_HOLDOFF_US:     cfg.holdoff_us     <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // per-stage ready so bubbles collapse under backpressure
  always_comb begin
    rdyo     = !vo || m_tready;
    rdy3     = !v3 || rdyo;
    rdy2     = !v2 || rdy3;
    rdy1     = !v1 || rdy2;
    s_tready = rdy1;
    accept   = s_tvalid && s_tready;
    ld.ld2   = rdy2 && v1;
    ld.ld3   = rdy3 && v2;
    ldo      = rdyo && v3;
  end

  uer_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .start_req  (s_tdata[0]),
    .echo_level (s_tdata[1]),
    .cfg        (cfg),
    .res        (res)
  );

  uer_dist u_dist (
    .clk                (clk),
    .ld                 (ld),
    .echo_time_us       (s1.echo_time_us),
    .temperature_tenths (temperature_tenths),
    .distance_10um      (dist_sat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      vo <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= accept;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
      if (rdyo) begin
        vo <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= res;
    end
    if (ld.ld2) begin
      s2 <= s1;
    end
    if (ld.ld3) begin
      s3 <= s2;
    end
    if (ldo) begin
      om    <= s3;
      odist <= s3.dist_en ? dist_sat : '0;
    end
  end

  assign m_tvalid = vo;
  assign m_tdata  = {2'b00, odist, om.echo_time_us, om.status, om.done_res,
                     om.busy_res, om.pin_is_output, om.pin_drive_high};

endmodule

`default_nettype wire

// File: sv/uer_ctrl.sv
`default_nettype none

module uer_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 accept,
  input  wire                 start_req,
  input  wire                 echo_level,
  input  uer_pkg::timing_cfg_t cfg,
  output uer_pkg::meas_t      res
);
  import uer_pkg::*;

  typedef enum logic [2:0] {
    IDLE,
    TRIGGER,
    WAIT_RISE,
    WAIT_FALL,
    HOLDOFF
  } phase_t;

  phase_t              phase, phase_next;
  logic [PRESC_W-1:0]  presc, presc_next;
  logic [US_W-1:0]     us_cnt, us_cnt_next;
  logic [US_W-1:0]     echo_cnt, echo_cnt_next;
  logic                last_echo;

  logic [9:0]          period;
  logic [PRESC_W-1:0]  period1, period2, presc_inc;
  logic                wrap1, wrap2;
  logic [PRESC_W-1:0]  presc_adv, presc_f;
  logic [US_W-1:0]     us_adv, echo_f;
  logic                half;
  logic [US_W:0]       etime_raw, elapsed;
  logic [US_W-1:0]     etime_sat;
  logic                rise, fall;
  logic                done, stat;
  logic [US_W-1:0]     etime;
  logic                ok;

  always_comb begin
    period    = (cfg.ticks_per_us == '0) ? 10'd1 : cfg.ticks_per_us;
    period1   = {1'b0, period};
    period2   = {period, 1'b0};
    presc_inc = presc + 1'b1;
    rise      = echo_level && !last_echo;
    fall      = !echo_level && last_echo;

    // one microsecond prescaler step
    wrap1     = presc_inc >= period1;
    presc_adv = wrap1 ? '0 : presc_inc;
    us_adv    = (wrap1 && us_cnt != US_MAX) ? us_cnt + 1'b1 : us_cnt;

    // falling-edge wait counts double periods
    wrap2     = presc_inc >= period2;
    presc_f   = wrap2 ? '0 : presc_inc;
    echo_f    = (wrap2 && echo_cnt != US_MAX) ? echo_cnt + 1'b1 : echo_cnt;
    half      = presc_f >= period1;
    etime_raw = {1'b0, echo_f} + {{US_W{1'b0}}, half};
    etime_sat = etime_raw[US_W] ? US_MAX : etime_raw[US_W-1:0];
    elapsed   = {echo_f, half};
  end

  always_comb begin
    phase_next    = phase;
    presc_next    = presc;
    us_cnt_next   = us_cnt;
    echo_cnt_next = echo_cnt;
    done          = 1'b0;
    stat          = 1'b0;
    etime         = '0;
    ok            = 1'b0;
    unique case (phase)
      IDLE: begin
        if (start_req) begin
          phase_next    = TRIGGER;
          presc_next    = '0;
          us_cnt_next   = '0;
          echo_cnt_next = '0;
        end
      end
      TRIGGER: begin
        presc_next  = presc_adv;
        us_cnt_next = us_adv;
        if (us_adv >= {10'd0, cfg.trigger_us}) begin
          phase_next    = WAIT_RISE;
          presc_next    = '0;
          us_cnt_next   = '0;
          echo_cnt_next = '0;
        end
      end
      WAIT_RISE: begin
        if (rise) begin
          phase_next    = WAIT_FALL;
          presc_next    = '0;
          us_cnt_next   = '0;
          echo_cnt_next = '0;
        end else begin
          presc_next  = presc_adv;
          us_cnt_next = us_adv;
          if (us_adv >= cfg.edge_wait_us) begin
            done = 1'b1;
            stat = 1'b1;
          end
        end
      end
      WAIT_FALL: begin
        presc_next    = presc_f;
        echo_cnt_next = echo_f;
        if (fall) begin
          done  = 1'b1;
          etime = etime_sat;
          if (etime_sat > cfg.max_one_way_us) begin
            stat = 1'b1;
          end else begin
            ok = 1'b1;
          end
        end else if (elapsed >= {1'b0, cfg.edge_wait_us}) begin
          done = 1'b1;
          stat = 1'b1;
        end
      end
      HOLDOFF: begin
        presc_next  = presc_adv;
        us_cnt_next = us_adv;
        if (us_adv >= {2'd0, cfg.holdoff_us}) begin
          phase_next    = IDLE;
          presc_next    = '0;
          us_cnt_next   = '0;
          echo_cnt_next = '0;
        end
      end
      default: begin
        phase_next    = IDLE;
        presc_next    = '0;
        us_cnt_next   = '0;
        echo_cnt_next = '0;
      end
    endcase
    if (done) begin
      phase_next    = HOLDOFF;
      presc_next    = '0;
      us_cnt_next   = '0;
      echo_cnt_next = '0;
    end

    res.pin_drive_high = (phase_next == TRIGGER);
    res.pin_is_output  = (phase_next == TRIGGER);
    res.busy_res       = (phase_next != IDLE);
    res.done_res       = done;
    res.status         = stat;
    res.echo_time_us   = etime;
    res.dist_en        = ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= IDLE;
      presc     <= '0;
      us_cnt    <= '0;
      echo_cnt  <= '0;
      last_echo <= 1'b0;
    end else if (accept) begin
      phase     <= phase_next;
      presc     <= presc_next;
      us_cnt    <= us_cnt_next;
      echo_cnt  <= echo_cnt_next;
      last_echo <= echo_level;
    end
  end

endmodule

`default_nettype wire

// File: sv/uer_dist.sv
`default_nettype none

module uer_dist (
  input  wire                         clk,
  input  uer_pkg::pipe_ld_t           ld,
  input  wire [uer_pkg::US_W-1:0]     echo_time_us,
  input  wire signed [11:0]           temperature_tenths,
  output logic [uer_pkg::DIST_W-1:0]  distance_10um
);
  import uer_pkg::*;

  logic signed [16:0] temp_ext;
  logic signed [16:0] speed_s;
  logic [15:0]        speed;
  logic [33:0]        prod;
  logic [30:0]        prod_div8;
  logic [62:0]        recip_prod;
  logic [24:0]        quot;

  always_comb begin
    temp_ext   = 17'(temperature_tenths);
    speed_s    = SPEED_BASE + temp_ext * SPEED_SLOPE;
    speed      = speed_s[15:0];
    prod_div8  = prod[33:3];
    recip_prod = 63'(prod_div8) * 63'(RECIP_125);
    distance_10um = (quot > 25'(DIST_MAX)) ? DIST_MAX : quot[DIST_W-1:0];
  end

  // time * speed, then shift right by 3 and floor divide by 125 via reciprocal
  always_ff @(posedge clk) begin
    if (ld.ld2) begin
      prod <= 34'(echo_time_us) * 34'(speed);
    end
    if (ld.ld3) begin
      quot <= recip_prod[62:RECIP_SHIFT];
    end
  end

endmodule

`default_nettype wire

// File: sv/uer_chk.sv
`default_nettype none

module uer_chk (
  input wire        clk,
  input wire        rst,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [47:0] m_tdata
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output word present right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output word changed");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[3] |-> m_tdata[2] && !m_tdata[0])
    else $error("done without busy or during trigger");

  a_pin_pair: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[1] && m_tdata[2])
    else $error("trigger drive without output enable or busy");

  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[3] |-> m_tdata[47:4] == 44'd0)
    else $error("result fields nonzero without done");

endmodule

bind ultrasonic_echo_ranger uer_chk u_uer_chk (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

// File: tb/sv/tb_top.sv
`default_nettype none

module tb_top;
  import uer_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
  localparam longint SOUND_BASE = 3315000;
  localparam longint SOUND_SLOPE = 600;
  localparam longint DIST_DIV = 100000;
  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned RANDOM_TICKS = 1150;

  typedef enum logic [2:0] {ST_IDLE, ST_PULSE, ST_RISE, ST_FALL, ST_QUIET} ranger_phase_t;
  typedef enum {SHAPE_ECHO, SHAPE_LATE_RISE, SHAPE_STUCK_HIGH, SHAPE_BROKEN} ping_shape_t;

  typedef struct packed {
    logic start;
    logic echo;
  } tick_t;

  typedef struct packed {
    logic [DIST_W-1:0] dist_10um;
    logic [US_W-1:0]   echo_us;
    logic              status;
    logic              done;
    logic              busy;
    logic              pin_output;
    logic              pin_high;
  } reading_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = '0;       // start_req, echo_level
  logic m_tvalid;
  logic m_tready = 1'b0;
  // pin_drive_high, pin_is_output, busy_res, done_res, status,
  // echo_time_us[17:0], distance_10um[22:0]
  logic [47:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // ranger state and register copies
  ranger_phase_t ph = ST_IDLE;
  int unsigned presc = 0;
  int unsigned us_cnt = 0;
  int unsigned dbl_cnt = 0;
  logic last_lvl = 1'b0;
  logic [9:0] cf_tpu = 10'd240;
  logic signed [11:0] cf_temp = 12'sd200;
  logic [7:0] cf_trig = 8'd5;
  logic [US_W-1:0] cf_wait = 18'd185000;
  logic [US_W-1:0] cf_limit = 18'd185000;
  logic [15:0] cf_quiet = 16'd200;

  tick_t ticks_to_send[$];
  reading_t pending_readings[$];
  int unsigned words_queued = 0;
  int unsigned words_out = 0;
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;
  logic word_taken = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned gap_max = 0;
  logic [31:0] ready_pat = '1;
  logic [4:0] pat_pos = '0;

  ultrasonic_echo_ranger uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic void restart_counts();
    presc = 0;
    us_cnt = 0;
    dbl_cnt = 0;
  endfunction

  function automatic void count_us(int unsigned per);
    presc++;
    if (presc >= per) begin
      presc = 0;
      if (us_cnt < US_MAX) us_cnt++;
    end
  endfunction

  function automatic reading_t ranger_tick(logic start, logic echo);
    reading_t w;
    logic rise, fall;
    int unsigned per, half, et, el;
    longint spd, d;
    w = '0;
    per = (cf_tpu == 0) ? 1 : cf_tpu;
    rise = echo && !last_lvl;
    fall = !echo && last_lvl;
    case (ph)
      ST_IDLE: begin
        if (start) begin
          ph = ST_PULSE;
          restart_counts();
        end
      end
      ST_PULSE: begin
        count_us(per);
        if (us_cnt >= cf_trig) begin
          ph = ST_RISE;
          restart_counts();
        end
      end
      ST_RISE: begin
        if (rise) begin
          ph = ST_FALL;
          restart_counts();
        end else begin
          count_us(per);
          if (us_cnt >= cf_wait) begin
            w.done = 1'b1;
            w.status = 1'b1;
          end
        end
      end
      ST_FALL: begin
        presc++;
        if (presc >= 2 * per) begin
          presc = 0;
          if (dbl_cnt < US_MAX) dbl_cnt++;
        end
        half = (presc >= per) ? 1 : 0;
        if (fall) begin
          et = dbl_cnt + half;
          if (et > US_MAX) et = US_MAX;
          w.done = 1'b1;
          w.echo_us = et[US_W-1:0];
          if (et > cf_limit) begin
            w.status = 1'b1;
          end else begin
            spd = SOUND_BASE + SOUND_SLOPE * longint'(cf_temp);
            d = (spd <= 0) ? 0 : (longint'(et) * spd) / DIST_DIV;
            if (d > DIST_MAX) d = DIST_MAX;
            w.dist_10um = d[DIST_W-1:0];
          end
        end else begin
          el = 2 * dbl_cnt + half;
          if (el >= cf_wait) begin
            w.done = 1'b1;
            w.status = 1'b1;
          end
        end
      end
      ST_QUIET: begin
        count_us(per);
        if (us_cnt >= cf_quiet) begin
          ph = ST_IDLE;
          restart_counts();
        end
      end
      default: begin
        ph = ST_IDLE;
        restart_counts();
      end
    endcase
    if (w.done) begin
      ph = ST_QUIET;
      restart_counts();
    end
    last_lvl = echo;
    w.pin_high = (ph == ST_PULSE);
    w.pin_output = (ph == ST_PULSE);
    w.busy = (ph != ST_IDLE);
    return w;
  endfunction

  function automatic void check_field(string field, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      fail_count++;
    end
  endfunction

  function automatic int unsigned cap_at(int unsigned v, int unsigned lim);
    return (v > lim) ? lim : v;
  endfunction

  // word sender
  always @(negedge clk) begin
    tick_t t;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || word_taken) begin
      if (gap_left > 0 || ticks_to_send.size() == 0) begin
        s_tvalid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        t = ticks_to_send.pop_front();
        s_tdata <= {6'b0, t.echo, t.start};
        s_tvalid <= 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = $urandom_range(0, gap_max);
        end else begin
          burst_left--;
        end
      end
    end
  end

  always @(negedge clk) begin
    m_tready <= ready_pat[pat_pos];
    pat_pos <= pat_pos + 1'b1;
  end

  // accepted words on both sides
  always @(posedge clk) begin
    reading_t want, got;
    word_taken = 1'b0;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        word_taken = 1'b1;
        pending_readings.push_back(ranger_tick(s_tdata[0], s_tdata[1]));
      end
      if (m_tvalid && m_tready) begin
        words_out++;
        got = m_tdata[45:0];
        if (pending_readings.size() == 0) begin
          $error("output word with no reading pending");
          fail_count++;
        end else begin
          want = pending_readings.pop_front();
          check_field("pin_drive_high", want.pin_high, got.pin_high);
          check_field("pin_is_output", want.pin_output, got.pin_output);
          check_field("busy_res", want.busy, got.busy);
          check_field("done_res", want.done, got.done);
          check_field("status", want.status, got.status);
          check_field("echo_time_us", want.echo_us, got.echo_us);
          check_field("distance_10um", want.dist_10um, got.dist_10um);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic add_tick(logic start, logic echo);
    ticks_to_send.push_back({start, echo});
    words_queued++;
  endtask

  task automatic add_run(logic start, logic echo, int unsigned n);
    repeat (n) add_tick(start, echo);
  endtask

  task automatic settle();
    while (words_out != words_queued) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_TICKS_PER_US: cf_tpu = data[9:0];
      REG_TEMPERATURE: cf_temp = data[11:0];
      REG_TRIGGER_US: cf_trig = data[7:0];
      REG_EDGE_WAIT_US: cf_wait = data[US_W-1:0];
      REG_MAX_ONE_WAY_US: cf_limit = data[US_W-1:0];
      REG_HOLDOFF_US: cf_quiet = data[15:0];
      default: ;
    endcase
  endtask

  // upper bits of the narrow registers carry junk
  task automatic apply_setup(int unsigned tpu, int temp, int unsigned trig,
                             int unsigned wait_us, int unsigned limit_us, int unsigned quiet_us);
    logic [31:0] rnd;
    logic [CFG_DATA_W-1:0] junk;
    rnd = $urandom;
    junk = rnd[CFG_DATA_W-1:0];
    write_reg(REG_TICKS_PER_US, {junk[17:10], tpu[9:0]});
    write_reg(REG_TEMPERATURE, {junk[17:12], temp[11:0]});
    write_reg(REG_TRIGGER_US, {junk[17:8], trig[7:0]});
    write_reg(REG_EDGE_WAIT_US, wait_us[17:0]);
    write_reg(REG_MAX_ONE_WAY_US, limit_us[17:0]);
    write_reg(REG_HOLDOFF_US, {junk[17:16], quiet_us[15:0]});
    if ($urandom_range(0, 1)) write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, junk);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic pick_pacing();
    gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
    ready_pat = ($urandom_range(0, 2) == 0) ? '1 : ($urandom | 32'h1);
  endtask

  task automatic add_ping(ping_shape_t shape);
    int unsigned per, lo, hi, quiet;
    per = (cf_tpu == 0) ? 1 : cf_tpu;
    if (shape == SHAPE_BROKEN) begin
      repeat ($urandom_range(3, 20)) add_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end else begin
      add_tick(1'b1, 1'b0);
      repeat (per * cf_trig + 1) add_tick($urandom_range(0, 3) == 0, 1'b0);
      if (shape == SHAPE_LATE_RISE) lo = cap_at(per * cf_wait + $urandom_range(1, 3), 200);
      else lo = $urandom_range(0, 4);
      repeat (lo) add_tick($urandom_range(0, 7) == 0, 1'b0);
      if (shape == SHAPE_STUCK_HIGH) hi = cap_at(per * cf_wait + $urandom_range(1, 3), 200);
      else hi = $urandom_range(1, cap_at(2 * per * (cf_limit + 1) + per, 60));
      repeat (hi) add_tick($urandom_range(0, 7) == 0, 1'b1);
      quiet = cap_at(per * cf_quiet + 2, 40) + $urandom_range(0, 3);
      repeat (quiet) add_tick(1'b0, 1'b0);
    end
  endtask

  task automatic run_phase(int unsigned pings);
    int unsigned r;
    ping_shape_t shape;
    pick_pacing();
    repeat (pings) begin
      r = $urandom_range(0, 19);
      if (r < 12) shape = SHAPE_ECHO;
      else if (r < 15) shape = SHAPE_LATE_RISE;
      else if (r < 18) shape = SHAPE_STUCK_HIGH;
      else shape = SHAPE_BROKEN;
      add_ping(shape);
    end
    settle();
  endtask

  initial begin
    int unsigned base;
    int unsigned tpu;
    int temp;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset values, start again while busy
    pick_pacing();
    add_run(1'b1, 1'b0, 1);
    add_run(1'b0, 1'b0, 2);
    add_run(1'b1, 1'b1, 1);
    settle();

    // zero ticks per us, zero trigger, zero wait, zero holdoff
    apply_setup(0, -400, 0, 0, 1, 0);
    pick_pacing();
    add_run(1'b0, 1'b0, 4);
    add_run(1'b1, 1'b0, 1);
    add_run(1'b0, 1'b0, 1);
    add_run(1'b0, 1'b1, 1);
    add_run(1'b0, 1'b0, 2);
    settle();

    // good echo, then one over the one-way limit
    apply_setup(1, 1250, 1, 6, 1, 1);
    pick_pacing();
    add_run(1'b1, 1'b0, 1);
    add_run(1'b0, 1'b0, 2);
    add_run(1'b0, 1'b1, 2);
    add_run(1'b0, 1'b0, 2);
    add_run(1'b1, 1'b0, 1);
    add_run(1'b0, 1'b0, 2);
    add_run(1'b0, 1'b1, 4);
    add_run(1'b0, 1'b0, 2);
    settle();

    base = words_queued;
    apply_setup(1023, 1250, 0, 0, 1, 0);
    run_phase(4);
    apply_setup(1, -400, 255, 262143, 262143, 65535);
    run_phase(1);
    apply_setup(2, -2048, 3, 40, 262143, 3);
    run_phase(3);
    apply_setup(3, 2047, 1, 25, 20, 2);
    run_phase(3);
    while (words_queued - base < RANDOM_TICKS) begin
      tpu = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
      if ($urandom_range(0, 5) == 0) temp = int'($urandom_range(0, 4095)) - 2048;
      else temp = int'($urandom_range(0, 1650)) - 400;
      apply_setup(tpu, temp, $urandom_range(0, 4), $urandom_range(0, 30),
                  $urandom_range(0, 20), $urandom_range(0, 12));
      run_phase($urandom_range(2, 5));
    end

    repeat (8) @(negedge clk);
    if (pending_readings.size() != 0) begin
      $error("%0d readings never arrived", pending_readings.size());
    end
    if (fail_count == 0 && pending_readings.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
